/* design/char_lcd_4bit_bus_sequencer_unit_macros.svh */
// ---------------------------------------------------------------------------
// LCD bus sequencer assertion macros
// Shorthand for clocked assertions, reset-qualified, same-cycle and next-cycle.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_BUS_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_4BIT_BUS_SEQUENCER_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define LCDSEQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lcdseq_pkg.sv */
// ---------------------------------------------------------------------------
// LCD bus sequencer package
// Request codes, microcode word format, register map and config bundle.
// ---------------------------------------------------------------------------
package lcdseq_pkg;

   // request codes
   localparam logic [2:0] OP_DATA   = 3'd0;
   localparam logic [2:0] OP_CMD    = 3'd1;
   localparam logic [2:0] OP_CURSOR = 3'd2;
   localparam logic [2:0] OP_INIT   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // cursor row base addresses
   localparam logic [1:0] ROW_FIRST   = 2'd0;
   localparam logic [1:0] ROW_SECOND  = 2'd1;
   localparam logic [7:0] ROW0_BASE   = 8'h80;
   localparam logic [7:0] ROW1_BASE   = 8'hC0;

   // register map (bit 2 of the byte address picks the register)
   localparam logic REG_ENABLE_HIGH = 1'b0;
   localparam logic REG_ENABLE_LOW  = 1'b1;
   localparam int   CSR_AW          = 3;
   localparam logic [7:0] HOLD_RESET = 8'd20;

   // microcode store
   localparam int UC_DEPTH = 54;
   localparam int UC_AW    = $clog2(UC_DEPTH);
   localparam logic [UC_AW-1:0] ENTRY_BYTE  = UC_AW'(0);
   localparam logic [UC_AW-1:0] ENTRY_CLEAR = UC_AW'(4);
   localparam logic [UC_AW-1:0] ENTRY_INIT  = UC_AW'(9);

   typedef enum logic [1:0] {
      NIB_OPER_HI = 2'd0,
      NIB_OPER_LO = 2'd1,
      NIB_CONST   = 2'd2,
      NIB_HELD    = 2'd3
   } nib_src_type;

   typedef enum logic [1:0] {
      HOLD_EN_HIGH = 2'd0,
      HOLD_EN_LOW  = 2'd1,
      HOLD_CONST   = 2'd2
   } hold_src_type;

   typedef struct packed {
      nib_src_type  src;
      logic         en;
      hold_src_type hold;
      logic [7:0]   konst;  // nibble in [3:0] or wait time in ms
      logic         last;   // final step: sequencer stops
   } ucode_type;

   typedef struct packed {
      logic [7:0] enable_high_ms;
      logic [7:0] enable_low_ms;
   } cfg_type;

   function automatic ucode_type uc_nib(nib_src_type src, logic en, logic [3:0] k,
                                        logic last);
      ucode_type w;
      w.src   = src;
      w.en    = en;
      w.hold  = en ? HOLD_EN_HIGH : HOLD_EN_LOW;
      w.konst = {4'h0, k};
      w.last  = last;
      return w;
   endfunction

   function automatic ucode_type uc_wait(logic [7:0] ms, logic last);
      ucode_type w;
      w.src   = NIB_HELD;
      w.en    = 1'b0;
      w.hold  = HOLD_CONST;
      w.konst = ms;
      w.last  = last;
      return w;
   endfunction

endpackage

/* design/lcdseq_rom.sv */
// ---------------------------------------------------------------------------
// LCD bus sequencer microcode ROM
// One control word per emitted bus interval; entry points per request type.
// ---------------------------------------------------------------------------
module lcdseq_rom
   import lcdseq_pkg::*;
(
   input  logic [UC_AW-1:0] addr,
   output ucode_type        word
);

   always_comb begin
      case (addr)
         // data / command / cursor: operand byte, high nibble first
         6'd0:  word = uc_nib(NIB_OPER_HI, 1'b1, 4'h0, 1'b0);
         6'd1:  word = uc_nib(NIB_OPER_HI, 1'b0, 4'h0, 1'b0);
         6'd2:  word = uc_nib(NIB_OPER_LO, 1'b1, 4'h0, 1'b0);
         6'd3:  word = uc_nib(NIB_OPER_LO, 1'b0, 4'h0, 1'b1);
         // clear display, then 2 ms
         6'd4:  word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd5:  word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd6:  word = uc_nib(NIB_CONST, 1'b1, 4'h1, 1'b0);
         6'd7:  word = uc_nib(NIB_CONST, 1'b0, 4'h1, 1'b0);
         6'd8:  word = uc_wait(8'd2, 1'b1);
         // power-on init
         6'd9:  word = uc_wait(8'd50, 1'b0);
         6'd10: word = uc_nib(NIB_CONST, 1'b1, 4'h3, 1'b0);
         6'd11: word = uc_nib(NIB_CONST, 1'b0, 4'h3, 1'b0);
         6'd12: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd13: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd14: word = uc_wait(8'd5, 1'b0);
         6'd15: word = uc_nib(NIB_CONST, 1'b1, 4'h3, 1'b0);
         6'd16: word = uc_nib(NIB_CONST, 1'b0, 4'h3, 1'b0);
         6'd17: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd18: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd19: word = uc_wait(8'd1, 1'b0);
         6'd20: word = uc_nib(NIB_CONST, 1'b1, 4'h3, 1'b0);
         6'd21: word = uc_nib(NIB_CONST, 1'b0, 4'h3, 1'b0);
         6'd22: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd23: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd24: word = uc_wait(8'd10, 1'b0);
         6'd25: word = uc_nib(NIB_CONST, 1'b1, 4'h2, 1'b0);
         6'd26: word = uc_nib(NIB_CONST, 1'b0, 4'h2, 1'b0);
         6'd27: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd28: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd29: word = uc_wait(8'd10, 1'b0);
         6'd30: word = uc_nib(NIB_CONST, 1'b1, 4'h2, 1'b0);
         6'd31: word = uc_nib(NIB_CONST, 1'b0, 4'h2, 1'b0);
         6'd32: word = uc_nib(NIB_CONST, 1'b1, 4'h8, 1'b0);
         6'd33: word = uc_nib(NIB_CONST, 1'b0, 4'h8, 1'b0);
         6'd34: word = uc_wait(8'd1, 1'b0);
         6'd35: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd36: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd37: word = uc_nib(NIB_CONST, 1'b1, 4'h8, 1'b0);
         6'd38: word = uc_nib(NIB_CONST, 1'b0, 4'h8, 1'b0);
         6'd39: word = uc_wait(8'd1, 1'b0);
         6'd40: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd41: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd42: word = uc_nib(NIB_CONST, 1'b1, 4'h1, 1'b0);
         6'd43: word = uc_nib(NIB_CONST, 1'b0, 4'h1, 1'b0);
         6'd44: word = uc_wait(8'd2, 1'b0);
         6'd45: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd46: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd47: word = uc_nib(NIB_CONST, 1'b1, 4'h6, 1'b0);
         6'd48: word = uc_nib(NIB_CONST, 1'b0, 4'h6, 1'b0);
         6'd49: word = uc_wait(8'd1, 1'b0);
         6'd50: word = uc_nib(NIB_CONST, 1'b1, 4'h0, 1'b0);
         6'd51: word = uc_nib(NIB_CONST, 1'b0, 4'h0, 1'b0);
         6'd52: word = uc_nib(NIB_CONST, 1'b1, 4'hC, 1'b0);
         6'd53: word = uc_nib(NIB_CONST, 1'b0, 4'hC, 1'b1);
         default: word = uc_wait(8'd0, 1'b1);
      endcase
   end

endmodule

/* design/lcdseq_csr.sv */
// ---------------------------------------------------------------------------
// LCD bus sequencer register block
// APB-style access to the enable high and enable low hold times.
// ---------------------------------------------------------------------------
module lcdseq_csr
   import lcdseq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [7:0] en_high_ff, en_high_in;
   logic [7:0] en_low_ff,  en_low_in;
   logic       wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      en_high_in = en_high_ff;
      en_low_in  = en_low_ff;
      if (wr) begin
         case (paddr[2])
            REG_ENABLE_HIGH: en_high_in = pwdata[7:0];
            REG_ENABLE_LOW:  en_low_in  = pwdata[7:0];
            default:         en_high_in = en_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_high_ff <= HOLD_RESET;
         en_low_ff  <= HOLD_RESET;
      end else begin
         en_high_ff <= en_high_in;
         en_low_ff  <= en_low_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ENABLE_HIGH: prdata = {24'h0, en_high_ff};
         REG_ENABLE_LOW:  prdata = {24'h0, en_low_ff};
         default:         prdata = 32'h0;
      endcase
   end

   assign cfg.enable_high_ms = en_high_ff;
   assign cfg.enable_low_ms  = en_low_ff;

endmodule

/* design/char_lcd_4bit_bus_sequencer_unit.sv */
// ---------------------------------------------------------------------------
// Character LCD 4-bit bus sequencer
// Expands LCD requests into timed RS/D7..D4/EN intervals via a microcode ROM.
// ---------------------------------------------------------------------------
// One request is taken at a time and turned into a run of bus intervals, one
// result per clock while the result side keeps up: data, command and cursor
// requests give 4 results, clear gives 5, and init gives 45. The request is
// accepted ahead of the first step, and no step is taken while the result
// side stalls a waiting result. The step counter walking the microcode ROM
// sets that pace. A new request is taken in the cycle after the final step is
// loaded, even if that result is still waiting at the output. Unused request
// codes are taken and dropped.
module char_lcd_4bit_bus_sequencer_unit
   import lcdseq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_byte_value,
   input  logic [1:0]        req_cursor_row,
   input  logic [7:0]        req_cursor_col,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_reg_select,
   output logic [3:0]        rsp_nibble,
   output logic              rsp_enable,
   output logic [7:0]        rsp_hold_ms,
   output logic              rsp_last,
   // config port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

`include "char_lcd_4bit_bus_sequencer_unit_macros.svh"

   cfg_type    cfg;
   ucode_type  uc;

   logic             busy_ff,   busy_in;
   logic [UC_AW-1:0] pc_ff,     pc_in;
   logic [7:0]       oper_ff,   oper_in;
   logic             rs_ff,     rs_in;
   logic [3:0]       held_ff,   held_in;
   logic             valid_ff,  valid_in;
   logic             out_rs_ff, out_rs_in;
   logic [3:0]       out_nib_ff, out_nib_in;
   logic             out_en_ff, out_en_in;
   logic [7:0]       out_ms_ff, out_ms_in;
   logic             out_last_ff, out_last_in;

   logic       accept;
   logic       step;
   logic [3:0] nib;

   lcdseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lcdseq_rom u_rom (
      .addr (pc_ff),
      .word (uc)
   );

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign step      = busy_ff && (!valid_ff || !rsp_stall);

   // request decode and step counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      oper_in = oper_ff;
      rs_in   = rs_ff;
      if (accept) begin
         case (req_op)
            OP_DATA: begin
               busy_in = 1'b1;
               pc_in   = ENTRY_BYTE;
               oper_in = req_byte_value;
               rs_in   = 1'b1;
            end
            OP_CMD: begin
               busy_in = 1'b1;
               pc_in   = ENTRY_BYTE;
               oper_in = req_byte_value;
               rs_in   = 1'b0;
            end
            OP_CURSOR: begin
               busy_in = 1'b1;
               pc_in   = ENTRY_BYTE;
               rs_in   = 1'b0;
               if (req_cursor_row == ROW_FIRST) begin
                  oper_in = req_cursor_col | ROW0_BASE;
               end else if (req_cursor_row == ROW_SECOND) begin
                  oper_in = req_cursor_col | ROW1_BASE;
               end else begin
                  oper_in = req_cursor_col;
               end
            end
            OP_INIT: begin
               busy_in = 1'b1;
               pc_in   = ENTRY_INIT;
            end
            OP_CLEAR: begin
               busy_in = 1'b1;
               pc_in   = ENTRY_CLEAR;
            end
            default: busy_in = 1'b0;
         endcase
      end else if (step) begin
         pc_in = pc_ff + UC_AW'(1);
         if (uc.last) begin
            busy_in = 1'b0;
         end
      end
   end

   // datapath driven by the control word
   always_comb begin
      case (uc.src)
         NIB_OPER_HI: nib = oper_ff[7:4];
         NIB_OPER_LO: nib = oper_ff[3:0];
         NIB_CONST:   nib = uc.konst[3:0];
         NIB_HELD:    nib = held_ff;
         default:     nib = held_ff;
      endcase
   end

   always_comb begin
      held_in     = held_ff;
      out_rs_in   = out_rs_ff;
      out_nib_in  = out_nib_ff;
      out_en_in   = out_en_ff;
      out_ms_in   = out_ms_ff;
      out_last_in = out_last_ff;
      valid_in    = valid_ff && rsp_stall;
      if (step) begin
         valid_in    = 1'b1;
         held_in     = nib;
         out_nib_in  = nib;
         out_en_in   = uc.en;
         out_last_in = uc.last;
         // only operand nibbles carry the request's RS level
         out_rs_in   = (uc.src == NIB_OPER_HI || uc.src == NIB_OPER_LO) ? rs_ff : 1'b0;
         case (uc.hold)
            HOLD_EN_HIGH: out_ms_in = cfg.enable_high_ms;
            HOLD_EN_LOW:  out_ms_in = cfg.enable_low_ms;
            HOLD_CONST:   out_ms_in = uc.konst;
            default:      out_ms_in = uc.konst;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         held_ff  <= 4'h0;
         pc_ff    <= ENTRY_BYTE;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         held_ff  <= held_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      oper_ff     <= oper_in;
      rs_ff       <= rs_in;
      out_rs_ff   <= out_rs_in;
      out_nib_ff  <= out_nib_in;
      out_en_ff   <= out_en_in;
      out_ms_ff   <= out_ms_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_enable     = out_en_ff;
   assign rsp_hold_ms    = out_ms_ff;
   assign rsp_last       = out_last_ff;

   `LCDSEQ_ASSERT_SAME(a_pc_in_rom, busy_ff, pc_ff < UC_AW'(UC_DEPTH), "step counter past ROM end")
   `LCDSEQ_ASSERT_NEXT(a_last_stops, step && uc.last, !busy_ff && rsp_last, "sequencer ran past last step")
   `LCDSEQ_ASSERT_NEXT(a_init_entry, accept && req_op == OP_INIT, busy_ff && pc_ff == ENTRY_INIT, "init entry point not loaded")

endmodule

/* sim/tb_char_lcd_4bit_bus_sequencer_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LCD bus sequencer testbench
// Feeds data, command, cursor, init and clear requests with bursty offers and
// a stalling result side, predicts every bus interval and checks each field.
// ---------------------------------------------------------------------------
module tb_char_lcd_4bit_bus_sequencer_unit;
   import lcdseq_pkg::*;

   localparam int CLOCK_HALF_NS   = 4;
   localparam int RESET_CYCLES    = 5;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int ITEMS_PER_PHASE = 56;
   localparam int LONG_HOLD_AT    = 400;   // results seen before the long hold
   localparam int LONG_HOLD_LEN   = 400;

   localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
   localparam logic [7:0] CLEAR_WAIT_MS     = 8'd2;
   localparam logic [7:0] POWER_ON_WAIT_MS  = 8'd50;
   localparam int         INIT_STEPS        = 9;
   localparam logic [7:0] INIT_CMDS  [INIT_STEPS] =
      '{8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
   // zero means no wait after that command
   localparam logic [7:0] INIT_WAITS [INIT_STEPS] =
      '{8'd5, 8'd1, 8'd10, 8'd10, 8'd1, 8'd1, 8'd2, 8'd1, 8'd0};

   typedef struct {
      logic [2:0] op;
      logic [7:0] byte_value;
      logic [1:0] cursor_row;
      logic [7:0] cursor_col;
   } lcd_request_t;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       enable;
      logic [7:0] hold_ms;
      logic       last;
   } bus_interval_t;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY
   } stall_mode_e;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_op = OP_DATA;
   logic [7:0]        req_byte_value = 8'h00;
   logic [1:0]        req_cursor_row = 2'd0;
   logic [7:0]        req_cursor_col = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_reg_select;
   logic [3:0]        rsp_nibble;
   logic              rsp_enable;
   logic [7:0]        rsp_hold_ms;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = 32'h0;
   logic [31:0]       prdata;
   logic              pready;

   lcd_request_t  pending_requests[$];
   bus_interval_t intervals_due[$];
   cfg_type       hold_cfg = '{enable_high_ms: HOLD_RESET, enable_low_ms: HOLD_RESET};
   logic [3:0]    held_nibble = 4'h0;
   int            error_count = 0;
   int            results_seen = 0;
   int            cycle_count = 0;
   bit            offer_taken = 1'b0;

   char_lcd_4bit_bus_sequencer_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .req_cursor_row (req_cursor_row),
      .req_cursor_col (req_cursor_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_enable     (rsp_enable),
      .rsp_hold_ms    (rsp_hold_ms),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- interval prediction ----------------
   task automatic queue_interval(input logic rs, input logic [3:0] nib, input logic en,
                                 input logic [7:0] ms);
      bus_interval_t iv;
      iv.reg_select = rs;
      iv.nibble     = nib;
      iv.enable     = en;
      iv.hold_ms    = ms;
      iv.last       = 1'b0;
      intervals_due.push_back(iv);
   endtask

   task automatic queue_nibble(input logic [3:0] nib, input logic rs);
      held_nibble = nib;
      queue_interval(rs, nib, 1'b1, hold_cfg.enable_high_ms);
      queue_interval(rs, nib, 1'b0, hold_cfg.enable_low_ms);
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic rs);
      queue_nibble(value[7:4], rs);
      queue_nibble(value[3:0], rs);
   endtask

   // waits keep D7..D4 at whatever nibble went out last
   task automatic queue_wait(input logic [7:0] ms);
      queue_interval(1'b0, held_nibble, 1'b0, ms);
   endtask

   task automatic expand_request(input lcd_request_t rq);
      int            first;
      logic [7:0]    addr;
      bus_interval_t tail;
      first = intervals_due.size();
      case (rq.op)
         OP_DATA: begin
            queue_byte(rq.byte_value, 1'b1);
         end
         OP_CMD: begin
            queue_byte(rq.byte_value, 1'b0);
         end
         OP_CURSOR: begin
            addr = rq.cursor_col;
            if (rq.cursor_row == ROW_FIRST) addr = addr | ROW0_BASE;
            else if (rq.cursor_row == ROW_SECOND) addr = addr | ROW1_BASE;
            queue_byte(addr, 1'b0);
         end
         OP_INIT: begin
            queue_wait(POWER_ON_WAIT_MS);
            for (int i = 0; i < INIT_STEPS; i++) begin
               queue_byte(INIT_CMDS[i], 1'b0);
               if (INIT_WAITS[i] != 8'd0) queue_wait(INIT_WAITS[i]);
            end
         end
         OP_CLEAR: begin
            queue_byte(CMD_CLEAR_DISPLAY, 1'b0);
            queue_wait(CLEAR_WAIT_MS);
         end
         default: ;   // unused codes are dropped
      endcase
      if (intervals_due.size() > first) begin
         tail = intervals_due.pop_back();
         tail.last = 1'b1;
         intervals_due.push_back(tail);
      end
   endtask

   // ---------------- request driver ----------------
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      offer_taken = !reset && req_valid && !req_stall;
      if (offer_taken)
         expand_request('{req_op, req_byte_value, req_cursor_row, req_cursor_col});
   end

   always @(negedge clock) begin
      lcd_request_t rq;
      if (!reset && (!req_valid || offer_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            rq = pending_requests.pop_front();
            req_op         <= rq.op;
            req_byte_value <= rq.byte_value;
            req_cursor_row <= rq.cursor_row;
            req_cursor_col <= rq.cursor_col;
            req_valid      <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
      end
   end

   // ---------------- result side ----------------
   stall_mode_e stall_mode = STALL_NONE;
   int          mode_left = 0;
   int          hold_left = 0;
   bit          did_long_hold = 1'b0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!did_long_hold && results_seen >= LONG_HOLD_AT && req_valid) begin
         // long hold while requests keep coming, so the input backs up
         did_long_hold = 1'b1;
         hold_left = LONG_HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      bus_interval_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (intervals_due.size() == 0) begin
            $error("result with no item pending: rs=%0b nib=%0h en=%0b hold=%0d last=%0b",
                   rsp_reg_select, rsp_nibble, rsp_enable, rsp_hold_ms, rsp_last);
            error_count++;
         end else begin
            want = intervals_due.pop_front();
            if (rsp_reg_select !== want.reg_select) begin
               $error("reg_select: expected %0b, got %0b", want.reg_select, rsp_reg_select);
               error_count++;
            end
            if (rsp_nibble !== want.nibble) begin
               $error("nibble: expected %0h, got %0h", want.nibble, rsp_nibble);
               error_count++;
            end
            if (rsp_enable !== want.enable) begin
               $error("enable: expected %0b, got %0b", want.enable, rsp_enable);
               error_count++;
            end
            if (rsp_hold_ms !== want.hold_ms) begin
               $error("hold_ms: expected %0d, got %0d", want.hold_ms, rsp_hold_ms);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // ---------------- sequence ----------------
   task automatic add_request(input logic [2:0] op, input logic [7:0] value,
                              input logic [1:0] row, input logic [7:0] col);
      pending_requests.push_back('{op, value, row, col});
   endtask

   task automatic add_random_requests(input int count);
      int         made;
      int         pick;
      logic [2:0] op;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) op = OP_DATA;
         else if (pick < 60) op = OP_CMD;
         else if (pick < 80) op = OP_CURSOR;
         else if (pick < 89) op = OP_CLEAR;
         else if (pick < 94) op = OP_INIT;
         else op = 3'(OP_CLEAR + $urandom_range(1, 3));
         add_request(op, 8'($urandom), 2'($urandom), 8'($urandom));
         if (op <= OP_CLEAR) made++;
      end
   endtask

   // returns once every offered item is taken and every interval came back
   task automatic wait_drained;
      while (pending_requests.size() != 0 || req_valid || intervals_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({reg_sel, 2'b00});
      pwdata  <= {24'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == REG_ENABLE_HIGH) hold_cfg.enable_high_ms = value;
      else hold_cfg.enable_low_ms = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[7:0] !== value) begin
         $error("csr readback: expected %0d, got %0d", value, prdata[7:0]);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // init first, so its opening wait shows the nibble held since reset
      add_request(OP_INIT,   8'h00, 2'd0, 8'h00);
      add_request(OP_DATA,   8'h00, 2'd3, 8'hFF);
      add_request(OP_DATA,   8'hFF, 2'd0, 8'h00);
      add_request(OP_DATA,   8'hA5, 2'd1, 8'h5A);
      add_request(OP_CMD,    8'h00, 2'd2, 8'hFF);
      add_request(OP_CMD,    8'hFF, 2'd0, 8'h00);
      add_request(OP_CMD,    8'h5A, 2'd3, 8'hA5);
      add_request(OP_CURSOR, 8'hFF, ROW_FIRST,  8'h00);
      add_request(OP_CURSOR, 8'h00, ROW_FIRST,  8'hFF);
      add_request(OP_CURSOR, 8'hFF, ROW_SECOND, 8'h00);
      add_request(OP_CURSOR, 8'h00, ROW_SECOND, 8'h3F);
      add_request(OP_CURSOR, 8'h00, 2'd2, 8'h7F);
      add_request(OP_CURSOR, 8'hFF, 2'd3, 8'hFF);
      add_request(OP_CURSOR, 8'h00, 2'd3, 8'h00);
      add_request(3'(OP_CLEAR + 3'd1), 8'hFF, 2'd3, 8'hFF);
      add_request(3'(OP_CLEAR + 3'd2), 8'h00, 2'd0, 8'h00);
      add_request(3'(OP_CLEAR + 3'd3), 8'hA5, 2'd1, 8'h5A);
      add_request(OP_CLEAR,  8'hFF, 2'd3, 8'hFF);
      add_request(OP_DATA,   8'h7E, 2'd0, 8'h00);
      add_request(OP_INIT,   8'hFF, 2'd3, 8'hFF);
      add_request(OP_CLEAR,  8'h00, 2'd0, 8'h00);
      wait_drained();

      csr_write(REG_ENABLE_HIGH, 8'd0);
      csr_write(REG_ENABLE_LOW, 8'd255);
      add_random_requests(ITEMS_PER_PHASE);
      wait_drained();

      csr_write(REG_ENABLE_HIGH, 8'd255);
      csr_write(REG_ENABLE_LOW, 8'd0);
      add_random_requests(ITEMS_PER_PHASE);
      wait_drained();

      csr_write(REG_ENABLE_HIGH, 8'd0);
      add_random_requests(ITEMS_PER_PHASE);
      wait_drained();

      csr_write(REG_ENABLE_HIGH, 8'd255);
      csr_write(REG_ENABLE_LOW, 8'd255);
      add_random_requests(ITEMS_PER_PHASE);
      wait_drained();

      csr_write(REG_ENABLE_HIGH, 8'($urandom));
      csr_write(REG_ENABLE_LOW, 8'($urandom));
      add_random_requests(ITEMS_PER_PHASE);
      wait_drained();

      if (error_count == 0 && intervals_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* char_lcd_4bit_bus_sequencer_unit.f */
+incdir+design
design/lcdseq_pkg.sv
design/lcdseq_rom.sv
design/lcdseq_csr.sv
design/char_lcd_4bit_bus_sequencer_unit.sv
sim/tb_char_lcd_4bit_bus_sequencer_unit.sv
